/* sv/tpes_pkg.sv */
// shared types, codes and constants of the timed pulse event scheduler
package tpes_pkg;

  // operation codes of an input beat
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SCHED_ABS = 3'd1,
    OP_SCHED_REL = 3'd2,
    OP_STOP      = 3'd3,
    OP_SET_PULSE = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_DUR_RANGE   = 2'd2,
    ST_PULSE_RANGE = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INC,
    S_SCAN,
    S_CHECK,
    S_FIND,
    S_RESP
  } state_t;

  // configuration register indexes
  localparam logic REG_LOCK = 1'b0;
  localparam logic REG_FIRE = 1'b1;

  localparam logic [11:0] LOCK_US_RESET  = 12'd750;
  localparam logic [11:0] FIRE_US_RESET  = 12'd2350;
  localparam logic [15:0] DUR_MIN        = 16'd10;
  localparam logic [15:0] DUR_MAX        = 16'd10000;
  localparam logic [13:0] PULSE_MS_RESET = 14'd180;

  // one slot table entry
  typedef struct packed {
    logic [31:0] target;
    logic [13:0] dur;
  } slot_entry_t;

  function automatic logic dur_ok(input logic [15:0] d);
    return (d >= DUR_MIN) && (d <= DUR_MAX);
  endfunction

endpackage

/* sv/tpes_slot_mem.sv */
// slot table storage: one write port, one registered read port
module tpes_slot_mem #(
  parameter int SLOTS = 12,
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  tpes_pkg::slot_entry_t wr_data,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output tpes_pkg::slot_entry_t rd_data
);
  import tpes_pkg::*;

  slot_entry_t mem [SLOTS];
  slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/timed_pulse_event_scheduler_unit.sv */
// timed pulse event scheduler: ms counter, slot table and actuator pulse control
//
// One input beat carries an operation: tick, schedule at an absolute time, schedule
// after a delay, stop, or set pulse length. Each beat gives exactly one result beat.
// Items are handled one at a time; in_stall is high from acceptance until the result
// has been placed in the output register, which holds it until the consumer takes it.
// All time arithmetic goes through one shared 32-bit add/subtract unit driven by a small
// sequencer, and the slot table sits in a memory with one registered read port.
// A tick runs the increment of the ms counter, a scan that reads one slot per cycle and
// compares it on the next, the pulse end check and the posting of the result. A
// schedule walks the valid bits from slot zero to the first free slot. Stop, set-pulse,
// out-of-range schedules and unknown codes go straight to posting the result.
// The slot valid bits are cleared at reset, so no clearing pass is needed; slot
// contents are written by a schedule before a compare ever acts on them.
module timed_pulse_event_scheduler_unit #(
  parameter int SLOTS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [11:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_time_value,
  input  logic [15:0] in_duration_ms,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [11:0] out_servo_pulse_us,
  output logic        out_motor_running,
  output logic [3:0]  out_fired_count
);
  import tpes_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(SLOTS - 1);

  // sequencer and scan state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;

  // architectural state
  logic [31:0]       now_r, now_nxt;
  logic [SLOTS-1:0]  active_r, active_nxt;
  logic              motor_on_r, motor_on_nxt;
  logic [31:0]       motor_start_r, motor_start_nxt;
  logic [13:0]       pulse_len_r, pulse_len_nxt;
  logic [11:0]       lock_us_r, fire_us_r;

  // latched item
  op_t               op_r, op_nxt;
  logic [31:0]       tv_r, tv_nxt;
  logic [13:0]       dur_r, dur_nxt;

  // result under construction
  status_t           status_r, status_nxt;
  logic [3:0]        fired_r, fired_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [11:0]       out_servo_r, out_servo_nxt;
  logic              out_motor_r, out_motor_nxt;
  logic [3:0]        out_fired_r, out_fired_nxt;

  // shared add/subtract unit
  logic [31:0]       alu_a, alu_b, alu_y;
  logic              alu_sub;

  // slot memory
  logic              mem_we;
  logic              mem_re;
  slot_entry_t       mem_wdata;
  slot_entry_t       mem_rdata;

  tpes_slot_mem #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (idx_r[IDX_W-1:0]),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (mem_rdata)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_a   = now_r;
    alu_b   = 32'd0;
    alu_sub = 1'b0;
    case (state_r)
      S_INC: begin
        alu_b = 32'd1;
      end
      S_SCAN: begin
        // wrap-safe due test: now - target, top bit clear means due
        alu_b   = mem_rdata.target;
        alu_sub = 1'b1;
      end
      S_CHECK: begin
        // elapsed pulse time
        alu_b   = motor_start_r;
        alu_sub = 1'b1;
      end
      S_FIND: begin
        // target: tv alone, or now + tv for a relative schedule
        alu_a = (op_r == OP_SCHED_REL) ? now_r : 32'd0;
        alu_b = tv_r;
      end
      default: begin
        alu_b = 32'd0;
      end
    endcase
  end

  assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + {31'd0, alu_sub};

  assign mem_wdata.target = alu_y;
  assign mem_wdata.dur    = dur_r;

  assign in_stall = (state_r != S_IDLE);

  // sequencer: next state and datapath control
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    cmp_vld_nxt     = cmp_vld_r;
    cmp_idx_nxt     = cmp_idx_r;
    now_nxt         = now_r;
    active_nxt      = active_r;
    motor_on_nxt    = motor_on_r;
    motor_start_nxt = motor_start_r;
    pulse_len_nxt   = pulse_len_r;
    op_nxt          = op_r;
    tv_nxt          = tv_r;
    dur_nxt         = dur_r;
    status_nxt      = status_r;
    fired_nxt       = fired_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    // a waiting result leaves once taken
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_servo_nxt   = out_servo_r;
    out_motor_nxt   = out_motor_r;
    out_fired_nxt   = out_fired_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = op_t'(in_operation);
          tv_nxt      = in_time_value;
          dur_nxt     = in_duration_ms[13:0];
          status_nxt  = ST_OK;
          fired_nxt   = 4'd0;
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_RESP;
          case (op_t'(in_operation))
            OP_TICK: begin
              state_nxt = S_INC;
            end
            OP_SCHED_ABS, OP_SCHED_REL: begin
              if (dur_ok(in_duration_ms)) begin
                state_nxt = S_FIND;
              end else begin
                status_nxt = ST_DUR_RANGE;
              end
            end
            OP_STOP: begin
              active_nxt   = '0;
              motor_on_nxt = 1'b0;
            end
            OP_SET_PULSE: begin
              if (dur_ok(in_duration_ms)) begin
                pulse_len_nxt = in_duration_ms[13:0];
              end else begin
                status_nxt = ST_PULSE_RANGE;
              end
            end
            default: begin
              // unknown codes answer ok and change nothing
              status_nxt = ST_OK;
            end
          endcase
        end
      end

      S_INC: begin
        now_nxt   = alu_y;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        // read slot idx this cycle, compare it next cycle
        mem_re      = (idx_r < SLOTS_C);
        cmp_vld_nxt = (idx_r < SLOTS_C);
        cmp_idx_nxt = idx_r[IDX_W-1:0];
        if (idx_r < SLOTS_C) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        if (cmp_vld_r && active_r[cmp_idx_r] && !alu_y[31]) begin
          // fire: later slots override the pulse length
          active_nxt[cmp_idx_r] = 1'b0;
          pulse_len_nxt         = mem_rdata.dur;
          motor_on_nxt          = 1'b1;
          motor_start_nxt       = now_r;
          if (fired_r != 4'hF) begin
            fired_nxt = fired_r + 4'd1;
          end
        end
        if ((idx_r == SLOTS_C) && !cmp_vld_r) begin
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (motor_on_r && ((alu_y[31:14] != 18'd0) || (alu_y[13:0] >= pulse_len_r))) begin
          motor_on_nxt = 1'b0;
        end
        state_nxt = S_RESP;
      end

      S_FIND: begin
        // lowest free slot takes the event
        if (!active_r[idx_r[IDX_W-1:0]]) begin
          mem_we                       = 1'b1;
          active_nxt[idx_r[IDX_W-1:0]] = 1'b1;
          state_nxt                    = S_RESP;
        end else if (idx_r == LAST_C) begin
          status_nxt = ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_servo_nxt  = motor_on_r ? fire_us_r : lock_us_r;
          out_motor_nxt  = motor_on_r;
          out_fired_nxt  = fired_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      idx_r         <= '0;
      cmp_vld_r     <= 1'b0;
      now_r         <= 32'd0;
      active_r      <= '0;
      motor_on_r    <= 1'b0;
      motor_start_r <= 32'd0;
      pulse_len_r   <= PULSE_MS_RESET;
      status_r      <= ST_OK;
      fired_r       <= 4'd0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      cmp_vld_r     <= cmp_vld_nxt;
      now_r         <= now_nxt;
      active_r      <= active_nxt;
      motor_on_r    <= motor_on_nxt;
      motor_start_r <= motor_start_nxt;
      pulse_len_r   <= pulse_len_nxt;
      status_r      <= status_nxt;
      fired_r       <= fired_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_us_r <= LOCK_US_RESET;
      fire_us_r <= FIRE_US_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LOCK: begin
          lock_us_r <= cfg_wdata;
        end
        REG_FIRE: begin
          fire_us_r <= cfg_wdata;
        end
        default: begin
          lock_us_r <= lock_us_r;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    op_r         <= op_nxt;
    tv_r         <= tv_nxt;
    dur_r        <= dur_nxt;
    out_status_r <= out_status_nxt;
    out_servo_r  <= out_servo_nxt;
    out_motor_r  <= out_motor_nxt;
    out_fired_r  <= out_fired_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_servo_pulse_us = out_servo_r;
  assign out_motor_running  = out_motor_r;
  assign out_fired_count    = out_fired_r;

`ifndef NO_ASSERTIONS
  // every accepted beat moves the sequencer out of idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted beat did not start the sequencer");

  // a stop leaves the slot table empty
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_operation == OP_STOP)) |=> (active_r == '0))
    else $error("stop left active slots");

  // an error status never comes with fired slots
  a_err_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_fired_r == 4'd0))
    else $error("error result reports fired slots");

  // a compare only follows a read issued in the scan
  a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cmp_vld_r) |-> ($past(state_r) == S_SCAN))
    else $error("slot compare without a preceding read");

  // fired count never exceeds the number of slots
  a_fired_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fired_r <= SLOTS))
    else $error("fired count above slot count");
`endif

endmodule
